// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the power-map embedding RTL.
// Used by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check masked while reset is asserted.
`define GPM_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check active on every edge, reset included.
`define GPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/gpm_pkg.sv =====
// Shared types, constants and GF(2^n) helper functions for the power-map embedding.
// No dependencies; imported by every module of the block.
package gpm_pkg;

    localparam int MAX_FIELD_DEGREE = 12;
    localparam int MAX_EMBED_WIDTH  = 64;
    localparam int TOKEN_W          = 16;
    localparam int VOCAB_W          = 13;
    localparam int EWIDTH_W         = 7;
    localparam int EXP_W            = 5;
    localparam int DEG_W            = $clog2(MAX_FIELD_DEGREE);
    localparam int CFG_DATA_W       = 13;
    localparam int CFG_IDX_W        = 3;
    // one squaring stage per possible nonzero value of k
    localparam int SQ_STAGES        = (1 << EXP_W) - 1;

    localparam int VOCAB_RESET  = 4096;
    localparam int EWIDTH_RESET = 64;
    localparam int EXP_RESET    = 1;
    localparam int COEF_A_RESET = 1;
    localparam int COEF_B_RESET = 0;

    typedef logic [MAX_FIELD_DEGREE-1:0] t_elem;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOCAB_SIZE  = 3'd0,
        CFG_EMBED_WIDTH = 3'd1,
        CFG_EXPONENT_K  = 3'd2,
        CFG_COEF_A      = 3'd3,
        CFG_COEF_B      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [VOCAB_W-1:0]  vocab;
        logic [DEG_W-1:0]    deg_m1;   // field degree minus one
        t_elem               mask;
        t_elem               poly;     // reduction polynomial, top term dropped
        logic [EWIDTH_W-1:0] width;    // saturated embed width
        logic [EXP_W-1:0]    k;
        t_elem               coef_a;
        t_elem               coef_b;
    } t_cfg;

    // smallest n >= 1 with 2^n >= vs, capped at the maximum degree
    function automatic logic [DEG_W-1:0] field_degree(input logic [VOCAB_W-1:0] vs);
        logic [DEG_W-1:0] n;
        logic [VOCAB_W:0] lim;
        n = DEG_W'(MAX_FIELD_DEGREE);
        for (int i = MAX_FIELD_DEGREE - 1; i >= 1; i--) begin
            lim = (VOCAB_W + 1)'(1) << i;
            if ({1'b0, vs} <= lim) begin
                n = DEG_W'(i);
            end
        end
        return n;
    endfunction

    function automatic logic [MAX_FIELD_DEGREE:0] irr_poly(input logic [DEG_W-1:0] deg);
        logic [MAX_FIELD_DEGREE:0] p;
        case (deg)
            4'd1:    p = 13'd3;
            4'd2:    p = 13'd7;
            4'd3:    p = 13'd11;
            4'd4:    p = 13'd19;
            4'd5:    p = 13'd37;
            4'd6:    p = 13'd91;
            4'd7:    p = 13'd131;
            4'd8:    p = 13'd285;
            4'd9:    p = 13'd529;
            4'd10:   p = 13'd1135;
            4'd11:   p = 13'd2053;
            4'd12:   p = 13'd4331;
            default: p = '0;
        endcase
        return p;
    endfunction

    function automatic t_elem degree_mask(input logic [DEG_W-1:0] deg);
        t_elem m;
        m = '0;
        for (int i = 0; i < MAX_FIELD_DEGREE; i++) begin
            if (DEG_W'(i) < deg) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    // shift-and-add multiply modulo poly; bits above the degree are masked off
    function automatic t_elem gf_mul(input t_elem x, input t_elem y,
                                     input t_elem mask, input t_elem poly);
        t_elem r;
        t_elem xs;
        t_elem top;
        t_elem ys;
        logic  hi;
        r   = '0;
        xs  = x & mask;
        ys  = y & mask;
        top = mask ^ (mask >> 1);
        for (int i = 0; i < MAX_FIELD_DEGREE; i++) begin
            if (ys[i]) begin
                r = r ^ xs;
            end
            hi = |(xs & top);
            xs = (xs << 1) & mask;
            if (hi) begin
                xs = xs ^ poly;
            end
        end
        return r & mask;
    endfunction

endpackage

// ===== hdl/gpm_cfg.sv =====
// Configuration registers with derived field degree, mask and polynomial.
// Depends on gpm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gpm_cfg import gpm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    logic [DEG_W-1:0]    wr_deg;
    t_elem               wr_mask;
    t_elem               wr_poly;
    logic [EWIDTH_W-1:0] wr_width;
    logic [DEG_W-1:0]    rst_deg;
    t_elem               rst_mask;
    t_elem               rst_poly;

    assign wr_deg   = field_degree(i_cfg_data[VOCAB_W-1:0]);
    assign wr_mask  = degree_mask(wr_deg);
    assign wr_poly  = MAX_FIELD_DEGREE'(irr_poly(wr_deg)) & wr_mask;
    assign wr_width = (i_cfg_data[EWIDTH_W-1:0] > EWIDTH_W'(MAX_EMBED_WIDTH))
                    ? EWIDTH_W'(MAX_EMBED_WIDTH) : i_cfg_data[EWIDTH_W-1:0];
    assign rst_deg  = field_degree(VOCAB_W'(VOCAB_RESET));
    assign rst_mask = degree_mask(rst_deg);
    assign rst_poly = MAX_FIELD_DEGREE'(irr_poly(rst_deg)) & rst_mask;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VOCAB_SIZE: begin
                    n_cfg.vocab  = i_cfg_data[VOCAB_W-1:0];
                    n_cfg.deg_m1 = wr_deg - DEG_W'(1);
                    n_cfg.mask   = wr_mask;
                    n_cfg.poly   = wr_poly;
                end
                CFG_EMBED_WIDTH: n_cfg.width  = wr_width;
                CFG_EXPONENT_K:  n_cfg.k      = i_cfg_data[EXP_W-1:0];
                CFG_COEF_A:      n_cfg.coef_a = i_cfg_data[MAX_FIELD_DEGREE-1:0];
                CFG_COEF_B:      n_cfg.coef_b = i_cfg_data[MAX_FIELD_DEGREE-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vocab  <= VOCAB_W'(VOCAB_RESET);
            r_cfg.deg_m1 <= rst_deg - DEG_W'(1);
            r_cfg.mask   <= rst_mask;
            r_cfg.poly   <= rst_poly;
            r_cfg.width  <= EWIDTH_W'(EWIDTH_RESET);
            r_cfg.k      <= EXP_W'(EXP_RESET);
            r_cfg.coef_a <= MAX_FIELD_DEGREE'(COEF_A_RESET);
            r_cfg.coef_b <= MAX_FIELD_DEGREE'(COEF_B_RESET);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

    `GPM_ASSERT_RST(a_poly_in_mask, i_clk, i_rst_n, (r_cfg.poly & ~r_cfg.mask) == '0, "polynomial exceeds field mask")
    `GPM_ASSERT_RST(a_width_sat, i_clk, i_rst_n, r_cfg.width <= EWIDTH_W'(MAX_EMBED_WIDTH), "embed width not saturated")

endmodule

// ===== hdl/gpm_pow.sv =====
// Input stage, squaring chain for t^(2^k) and the final multiply by t.
// Depends on gpm_pkg.
module gpm_pow import gpm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [TOKEN_W-1:0] i_token,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    output logic               o_oor,
    output t_elem              o_prod
);

    logic  r_vld [SQ_STAGES+1];
    logic  r_oor [SQ_STAGES+1];
    t_elem r_t   [SQ_STAGES+1];
    t_elem r_p   [SQ_STAGES+1];

    logic  r_vld_m;
    logic  r_oor_m;
    t_elem r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= SQ_STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_vld_m <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s <= SQ_STAGES; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_vld_m <= r_vld[SQ_STAGES];
        end
    end

    // stage s squares only while s <= k, so the chain ends at t^(2^k)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_oor[0] <= i_token >= TOKEN_W'(i_cfg.vocab);
            r_t[0]   <= i_token[MAX_FIELD_DEGREE-1:0] & i_cfg.mask;
            r_p[0]   <= i_token[MAX_FIELD_DEGREE-1:0] & i_cfg.mask;
            for (int s = 1; s <= SQ_STAGES; s++) begin
                r_oor[s] <= r_oor[s-1];
                r_t[s]   <= r_t[s-1];
                r_p[s]   <= (i_cfg.k >= EXP_W'(s))
                          ? gf_mul(r_p[s-1], r_p[s-1], i_cfg.mask, i_cfg.poly)
                          : r_p[s-1];
            end
            r_oor_m <= r_oor[SQ_STAGES];
            r_prod  <= gf_mul(r_t[SQ_STAGES], r_p[SQ_STAGES], i_cfg.mask, i_cfg.poly);
        end
    end

    assign o_valid = r_vld_m;
    assign o_oor   = r_oor_m;
    assign o_prod  = r_prod;

endmodule

// ===== hdl/gpm_out.sv =====
// Affine stage a*x + b, embedding tiling and the output register.
// Depends on gpm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gpm_out import gpm_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic                        i_oor,
    input  t_elem                       i_prod,
    input  t_cfg                        i_cfg,
    output logic                        o_valid,
    output logic [MAX_EMBED_WIDTH-1:0]  o_embedding_bits,
    output t_elem                       o_field_value,
    output logic                        o_range_err
);

    logic  r_vld_v;
    logic  r_oor_v;
    t_elem r_val;

    logic                       r_vld_o;
    logic                       r_oor_o;
    t_elem                      r_val_o;
    logic [MAX_EMBED_WIDTH-1:0] r_bits_o;

    logic [MAX_FIELD_DEGREE-1:0] tile [MAX_EMBED_WIDTH];
    logic [MAX_EMBED_WIDTH-1:0]  bits_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_v <= 1'b0;
            r_vld_o <= 1'b0;
        end else if (i_en) begin
            r_vld_v <= i_valid;
            r_vld_o <= r_vld_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_oor_v <= i_oor;
            r_val   <= gf_mul(i_cfg.coef_a, i_prod, i_cfg.mask, i_cfg.poly)
                     ^ (i_cfg.coef_b & i_cfg.mask);
        end
    end

    // tile[j][d-1]: the bit that lands at position j for a degree-d field
    for (genvar J = 0; J < MAX_EMBED_WIDTH; J++) begin : g_pos
        for (genvar D = 1; D <= MAX_FIELD_DEGREE; D++) begin : g_deg
            localparam int Idx = D - 1 - (J % D);
            assign tile[J][D-1] = r_val[Idx];
        end
        assign bits_c[J] = tile[J][i_cfg.deg_m1] & (EWIDTH_W'(J) < i_cfg.width);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_oor_o  <= r_oor_v;
            r_val_o  <= r_oor_v ? '0 : r_val;
            r_bits_o <= r_oor_v ? '0 : bits_c;
        end
    end

    assign o_valid          = r_vld_o;
    assign o_embedding_bits = r_bits_o;
    assign o_field_value    = r_val_o;
    assign o_range_err      = r_oor_o;

    `GPM_ASSERT_RST(a_oor_zero, i_clk, i_rst_n, r_vld_o && r_oor_o |-> (r_bits_o == '0 && r_val_o == '0), "out of range result not zeroed")
    `GPM_ASSERT_RST(a_val_in_field, i_clk, i_rst_n, r_vld_o |-> (r_val_o & ~i_cfg.mask) == '0, "field value exceeds degree")
    `GPM_ASSERT_RST(a_bits_in_width, i_clk, i_rst_n, r_vld_o |-> (r_bits_o >> i_cfg.width) == '0, "embedding set beyond width")

endmodule

// ===== hdl/gf2n_power_map_token_embedding.sv =====
// Top level of the GF(2^n) power-map token embedding.
// Depends on gpm_pkg, gpm_cfg, gpm_pow, gpm_out and assert_macros.svh.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one token id per request.
//   Output channel (o_valid / i_stall) returns embedding bits, the field
//   value v = a*t^(2^k+1) + b and an out-of-range flag per request.
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data):
//   0 vocab size, 1 embed width, 2 exponent k, 3 coef a, 4 coef b. Write
//   only while no request is in flight.
//   From acceptance to o_valid a request passes one input stage, 31
//   squaring stages (one per nonzero k), the t multiply, the a*x+b stage
//   and the output register; one request per cycle unless stalled.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and o_stall rises in the same cycle; nothing is dropped or repeated.
//   Synchronous reset empties the pipeline and loads register defaults:
//   vocab 4096, width 64, k 1, a 1, b 0.
`include "assert_macros.svh"

module gf2n_power_map_token_embedding import gpm_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [TOKEN_W-1:0]          i_token,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [MAX_EMBED_WIDTH-1:0]  o_embedding_bits,
    output logic [MAX_FIELD_DEGREE-1:0] o_field_value,
    output logic                        o_range_err
);

    t_cfg  cfg;
    logic  pipe_en;
    logic  pow_valid;
    logic  pow_oor;
    t_elem pow_prod;

    // pipeline moves unless a finished result is held by the receiver
    assign pipe_en = !(o_valid && i_stall);
    assign o_stall = !pipe_en;

    gpm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    gpm_pow u_pow (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (pipe_en),
        .i_valid    (i_valid),
        .i_token    (i_token),
        .i_cfg      (cfg),
        .o_valid    (pow_valid),
        .o_oor      (pow_oor),
        .o_prod     (pow_prod)
    );

    gpm_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (pipe_en),
        .i_valid          (pow_valid),
        .i_oor            (pow_oor),
        .i_prod           (pow_prod),
        .i_cfg            (cfg),
        .o_valid          (o_valid),
        .o_embedding_bits (o_embedding_bits),
        .o_field_value    (o_field_value),
        .o_range_err      (o_range_err)
    );

    `GPM_ASSERT_ALWAYS(a_rst_clears_valid, i_clk, !i_rst_n |=> !o_valid, "valid survived reset")

endmodule

// ===== dv/gpm_embed_checker.sv =====
// Checker for the GF(2^n) power-map token embedding: tracks register writes,
// predicts each result from the accepted token and compares in order.
// Depends on gpm_pkg for widths and register indexes.
`timescale 1ns / 100ps

module gpm_embed_checker
    import gpm_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_req_valid,
    input  logic                        i_req_stall,
    input  logic [TOKEN_W-1:0]          i_token,
    input  logic                        i_rsp_valid,
    input  logic                        i_rsp_stall,
    input  logic [MAX_EMBED_WIDTH-1:0]  i_embedding_bits,
    input  logic [MAX_FIELD_DEGREE-1:0] i_field_value,
    input  logic                        i_range_err,
    output int                          o_fail_count,
    output int                          o_outstanding
);

    typedef struct packed {
        logic [MAX_EMBED_WIDTH-1:0] bits;
        t_elem                      value;
        logic                       oor;
    } t_embed_row;

    localparam logic [MAX_FIELD_DEGREE:0] REDUCING_POLY [MAX_FIELD_DEGREE+1] = '{
        13'd0, 13'd3, 13'd7, 13'd11, 13'd19, 13'd37, 13'd91,
        13'd131, 13'd285, 13'd529, 13'd1135, 13'd2053, 13'd4331
    };

    logic [VOCAB_W-1:0]  vocab_limit;
    logic [EWIDTH_W-1:0] embed_width;
    logic [EXP_W-1:0]    exp_k;
    t_elem               coef_a;
    t_elem               coef_b;

    t_embed_row expected_rows[$];
    int         fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic int unsigned degree_for_vocab(input logic [VOCAB_W-1:0] vs);
        int unsigned n;
        n = 1;
        while (n < MAX_FIELD_DEGREE && (32'd1 << n) < vs) begin
            n++;
        end
        return n;
    endfunction

    // poly_low is the reduction polynomial without its x^n term
    function automatic t_elem field_product(input t_elem x, input t_elem y,
                                            input int unsigned n, input t_elem poly_low);
        t_elem mask;
        t_elem top;
        t_elem r;
        t_elem xs;
        t_elem ys;
        logic  hi;
        mask = t_elem'((32'd1 << n) - 1);
        top  = t_elem'(32'd1 << (n - 1));
        r    = '0;
        xs   = x & mask;
        ys   = y & mask;
        for (int i = 0; i < n; i++) begin
            if (ys[0]) begin
                r = r ^ xs;
            end
            ys = ys >> 1;
            hi = |(xs & top);
            xs = (xs << 1) & mask;
            if (hi) begin
                xs = xs ^ poly_low;
            end
        end
        return r & mask;
    endfunction

    function automatic t_elem field_power(input t_elem base, input logic [32:0] e,
                                          input int unsigned n, input t_elem poly_low);
        t_elem r;
        t_elem sq;
        r  = t_elem'(1);
        sq = base;
        for (int i = 0; i < 33; i++) begin
            if (e[i]) begin
                r = field_product(r, sq, n, poly_low);
            end
            sq = field_product(sq, sq, n, poly_low);
        end
        return r;
    endfunction

    function automatic t_embed_row embed_token(input logic [TOKEN_W-1:0] tok);
        t_embed_row  row;
        int unsigned n;
        int unsigned width;
        int unsigned pos;
        t_elem       mask;
        t_elem       poly_low;
        t_elem       v;
        logic [32:0] e;
        row = '0;
        if (tok >= vocab_limit) begin
            row.oor = 1'b1;
            return row;
        end
        n        = degree_for_vocab(vocab_limit);
        mask     = t_elem'((32'd1 << n) - 1);
        poly_low = REDUCING_POLY[n][MAX_FIELD_DEGREE-1:0] & mask;
        e        = (33'd1 << exp_k) + 33'd1;
        // token is cut to its low n bits by the field ops
        v = field_product(coef_a, field_power(tok[MAX_FIELD_DEGREE-1:0], e, n, poly_low),
                          n, poly_low) ^ (coef_b & mask);
        width = (embed_width > MAX_EMBED_WIDTH) ? MAX_EMBED_WIDTH : embed_width;
        pos   = 0;
        for (int j = 0; j < width; j++) begin
            row.bits[j] = v[n - 1 - pos];
            pos = (pos + 1 == n) ? 0 : pos + 1;
        end
        row.value = v;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_embed_row want;
        if (!i_rst_n) begin
            vocab_limit   <= VOCAB_W'(VOCAB_RESET);
            embed_width   <= EWIDTH_W'(EWIDTH_RESET);
            exp_k         <= EXP_W'(EXP_RESET);
            coef_a        <= t_elem'(COEF_A_RESET);
            coef_b        <= t_elem'(COEF_B_RESET);
            expected_rows.delete();
            o_outstanding <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VOCAB_SIZE:  vocab_limit <= i_cfg_data[VOCAB_W-1:0];
                    CFG_EMBED_WIDTH: embed_width <= i_cfg_data[EWIDTH_W-1:0];
                    CFG_EXPONENT_K:  exp_k       <= i_cfg_data[EXP_W-1:0];
                    CFG_COEF_A:      coef_a      <= i_cfg_data[MAX_FIELD_DEGREE-1:0];
                    CFG_COEF_B:      coef_b      <= i_cfg_data[MAX_FIELD_DEGREE-1:0];
                    default: ;
                endcase
            end
            if (i_req_valid && !i_req_stall) begin
                expected_rows.insert(expected_rows.size(), embed_token(i_token));
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_rows.size() == 0) begin
                    report_mismatch("result with no request outstanding",
                                    i_embedding_bits, '0);
                end else begin
                    want = expected_rows.pop_front();
                    if (i_embedding_bits !== want.bits) begin
                        report_mismatch("embedding_bits", i_embedding_bits, want.bits);
                    end
                    if (i_field_value !== want.value) begin
                        report_mismatch("field_value", i_field_value, want.value);
                    end
                    if (i_range_err !== want.oor) begin
                        report_mismatch("range_err", i_range_err, want.oor);
                    end
                end
            end
            o_outstanding <= expected_rows.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Top of the power-map embedding testbench: clock, reset, register setup and
// token stimulus with random gaps and stalls.
// Depends on gpm_pkg, the block and gpm_embed_checker.
`timescale 1ns / 100ps

module tb_top;

    import gpm_pkg::*;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_idx = '0;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;
    logic                        req_valid = 1'b0;
    logic [TOKEN_W-1:0]          req_token = '0;
    logic                        rsp_stall = 1'b0;
    logic                        o_stall;
    logic                        o_valid;
    logic [MAX_EMBED_WIDTH-1:0]  o_embedding_bits;
    logic [MAX_FIELD_DEGREE-1:0] o_field_value;
    logic                        o_range_err;
    logic                        quiet = 1'b0;
    int                          fail_count;
    int                          outstanding;

    gf2n_power_map_token_embedding u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_valid          (req_valid),
        .o_stall          (o_stall),
        .i_token          (req_token),
        .o_valid          (o_valid),
        .i_stall          (rsp_stall),
        .o_embedding_bits (o_embedding_bits),
        .o_field_value    (o_field_value),
        .o_range_err      (o_range_err)
    );

    gpm_embed_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_req_valid      (req_valid),
        .i_req_stall      (o_stall),
        .i_token          (req_token),
        .i_rsp_valid      (o_valid),
        .i_rsp_stall      (rsp_stall),
        .i_embedding_bits (o_embedding_bits),
        .i_field_value    (o_field_value),
        .i_range_err      (o_range_err),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        rsp_stall <= !quiet && ($urandom_range(99) < 38);
    end

    initial begin
        #4_800_000;
        $display("gf2n_power_map_token_embedding test failed");
        $finish;
    end

    task automatic send_token(input logic [TOKEN_W-1:0] tok);
        while (!quiet && $urandom_range(99) < 38) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_token <= tok;
        @(posedge clk);
        while (o_stall) begin
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    // registers change only with no request in flight
    task automatic load_config(input int unsigned vs, input int unsigned ew,
                               input int unsigned k, input int unsigned a,
                               input int unsigned b);
        wait_drained();
        write_reg(CFG_VOCAB_SIZE, vs);
        write_reg(CFG_EMBED_WIDTH, ew);
        write_reg(CFG_EXPONENT_K, k);
        write_reg(CFG_COEF_A, a);
        write_reg(CFG_COEF_B, b);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        int unsigned vs;
        int unsigned ew;
        int unsigned k;
        int unsigned a;
        int unsigned pick;
        case ($urandom_range(9))
            0:       vs = 0;
            1:       vs = 1;
            2:       vs = 8191;
            3:       vs = 4096;
            default: vs = $urandom_range(4096, 2);
        endcase
        case ($urandom_range(5))
            0:       ew = 64;
            1:       ew = $urandom_range(127, 65);
            default: ew = $urandom_range(64);
        endcase
        k = ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(21, 1);
        a = ($urandom_range(9) == 0) ? 0 : $urandom_range(4095, 1);
        load_config(vs, ew, k, a, $urandom_range(4095));
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (vs != 0 && pick < 70) begin
                send_token(TOKEN_W'($urandom_range(vs - 1)));
            end else if (pick < 80) begin
                // right at the range boundary
                send_token(TOKEN_W'(vs + $urandom_range(1)));
            end else begin
                send_token(TOKEN_W'($urandom_range(65535)));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: 4096 tokens, degree 12
        send_token(16'd0);
        send_token(16'd1);
        send_token(16'd4095);
        send_token(16'd4096);
        send_token(16'hFFFF);
        send_token(16'h0AAA);
        send_token(16'h0555);

        // vocab above 2^12, width above 64, k zero, a zero
        load_config(8191, 127, 0, 0, 4095);
        send_token(16'd5000);
        send_token(16'd8190);
        send_token(16'd8191);

        // one-bit field, zero width, largest k
        load_config(1, 0, 31, 4095, 4095);
        send_token(16'd0);
        send_token(16'd1);

        load_config(2, 1, 21, 1, 1);
        send_token(16'd0);
        send_token(16'd1);
        send_token(16'd2);

        load_config(4096, 64, 21, 4095, 4095);
        send_token(16'd4095);
        send_token(16'd3000);

        // empty vocabulary
        load_config(0, 64, 1, 1, 0);
        send_token(16'd0);
        send_token(16'd1);

        for (int p = 0; p < 10; p++) begin
            quiet <= (p == 4);
            random_phase(100);
        end
        quiet <= 1'b0;

        wait_drained();
        repeat (40) @(posedge clk);
        if (fail_count == 0) begin
            $display("gf2n_power_map_token_embedding test passed");
        end else begin
            $display("gf2n_power_map_token_embedding test failed");
        end
        $finish;
    end

endmodule
